@@ src/bmhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// bmhpq_pkg
// Shared types and codes of the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package bmhpq_pkg;

  localparam int ID_W      = 16;
  localparam int PRIO_W    = 16;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 8;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 48;

  // action codes carried on s_tuser
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

endpackage

@@ src/binary_max_heap_priority_queue.sv @@
// A full push or an empty pop goes from transfer in straight to the result; otherwise the entry
// moves one heap level per cycle through the memory.
// Throughput: one item at a time; a new item is taken only once the previous one has reached the output register.
// A new item is taken while the previous result still waits in the output register.
// Reset: synchronous; empties the heap at once, the heap memory itself is not cleared.
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue
// Max-heap of (id, priority) entries held in one memory with two read ports.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue #(
  parameter int CAPACITY = 128
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [15:0] process_id, [31:16] priority_in
  input  logic [bmhpq_pkg::S_TDATA_W-1:0] s_tdata,
  // [0] action
  input  logic [0:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [1:0] status, [17:2] out_id, [33:18] out_priority, [41:34] occupancy, [47:42] zero
  output logic [bmhpq_pkg::M_TDATA_W-1:0] m_tdata
);
  import bmhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_POPLD = 6'b000010,
    S_UP    = 6'b000100,
    S_DOWN  = 6'b001000,
    S_PLACE = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t               state, state_next;
  logic [CW-1:0]        cnt, cnt_next;
  logic [AW-1:0]        pos, pos_next;
  entry_t               mov, mov_next;
  entry_t               res_ent, res_ent_next;
  logic [STATUS_W-1:0]  res_status, res_status_next;

  entry_t               mem [CAPACITY];
  entry_t               rd_a, rd_b;
  logic [AW-1:0]        addr_a, addr_b, wa;
  logic                 we;
  entry_t               wd;

  logic                 in_fire, out_load;
  logic [XW-1:0]        cnt_x, lft, rgt, nl, nr;
  logic [AW-1:0]        pos_m1, par, par_m1, par2, cnt_m1;
  logic                 use_r;
  entry_t               pick_ent;
  logic [AW-1:0]        pick_pos;
  logic [CW+OCC_W-1:0]  occ_ext;

  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_load = (state == S_FIN) && (!m_tvalid || m_tready);

  // heap index arithmetic
  assign cnt_x  = XW'(cnt);
  assign cnt_m1 = AW'(cnt - CW'(1));
  assign pos_m1 = pos - AW'(1);
  assign par    = pos_m1 >> 1;
  assign par_m1 = par - AW'(1);
  assign par2   = par_m1 >> 1;
  assign lft    = {1'b0, pos, 1'b1};
  assign rgt    = lft + XW'(1);
  assign use_r  = (rgt < cnt_x) && (rd_b.prio > rd_a.prio);
  assign pick_ent = use_r ? rd_b : rd_a;
  assign pick_pos = use_r ? rgt[AW-1:0] : lft[AW-1:0];
  assign nl     = {1'b0, pick_pos, 1'b1};
  assign nr     = nl + XW'(1);

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    pos_next        = pos;
    mov_next        = mov;
    res_ent_next    = res_ent;
    res_status_next = res_status;
    addr_a          = '0;
    addr_b          = '0;
    we              = 1'b0;
    wa              = pos;
    wd              = mov;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          res_ent_next    = '0;
          res_status_next = ST_OK;
          if (s_tuser[0] == ACT_PUSH) begin
            if (cnt == CW'(CAPACITY)) begin
              res_status_next = ST_FULL;
              state_next      = S_FIN;
            end else begin
              mov_next.id   = s_tdata[ID_W-1:0];
              mov_next.prio = s_tdata[ID_W+PRIO_W-1:ID_W];
              pos_next      = AW'(cnt);
              cnt_next      = cnt + CW'(1);
              if (cnt == '0) begin
                state_next = S_PLACE;
              end else begin
                // parent of the new slot
                addr_a     = AW'((cnt - CW'(1)) >> 1);
                state_next = S_UP;
              end
            end
          end else begin
            if (cnt == '0) begin
              res_status_next = ST_EMPTY;
              state_next      = S_FIN;
            end else begin
              addr_a     = '0;
              addr_b     = cnt_m1;
              cnt_next   = cnt - CW'(1);
              state_next = S_POPLD;
            end
          end
        end
      end
      S_POPLD: begin
        // root and last entry are out of the memory now
        res_ent_next = rd_a;
        mov_next     = rd_b;
        pos_next     = '0;
        if (cnt == '0) begin
          state_next = S_FIN;
        end else if (cnt > CW'(1)) begin
          addr_a     = AW'(1);
          addr_b     = (cnt > CW'(2)) ? AW'(2) : AW'(1);
          state_next = S_DOWN;
        end else begin
          we         = 1'b1;
          wa         = '0;
          wd         = rd_b;
          state_next = S_FIN;
        end
      end
      S_UP: begin
        we = 1'b1;
        if (mov.prio > rd_a.prio) begin
          // parent moves down into the hole
          wd       = rd_a;
          pos_next = par;
          if (par == '0) begin
            state_next = S_PLACE;
          end else begin
            addr_a = par2;
          end
        end else begin
          state_next = S_FIN;
        end
      end
      S_DOWN: begin
        we = 1'b1;
        if (mov.prio >= pick_ent.prio) begin
          state_next = S_FIN;
        end else begin
          // larger child moves up into the hole
          wd       = pick_ent;
          pos_next = pick_pos;
          if (nl < cnt_x) begin
            addr_a = nl[AW-1:0];
            addr_b = (nr < cnt_x) ? nr[AW-1:0] : nl[AW-1:0];
          end else begin
            state_next = S_PLACE;
          end
        end
      end
      S_PLACE: begin
        we         = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // heap memory, two registered read ports and one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    mov        <= mov_next;
    res_ent    <= res_ent_next;
    res_status <= res_status_next;
  end

  assign occ_ext = {{OCC_W{1'b0}}, cnt};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {6'b0, occ_ext[OCC_W-1:0], res_ent.prio, res_ent.id, res_status};
    end
  end

endmodule

@@ src/bmhpq_checker.sv @@
// ----------------------------------------------------------------------------
// bmhpq_checker
// Port-level checks of the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
module bmhpq_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [bmhpq_pkg::S_TDATA_W-1:0] s_tdata,
  input logic [0:0]                      s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [bmhpq_pkg::M_TDATA_W-1:0] m_tdata
);
  import bmhpq_pkg::*;

  logic [STATUS_W-1:0] st;
  logic [ID_W-1:0]     rid;
  logic [PRIO_W-1:0]   rprio;
  logic [OCC_W-1:0]    occ;

  assign st    = m_tdata[1:0];
  assign rid   = m_tdata[17:2];
  assign rprio = m_tdata[33:18];
  assign occ   = m_tdata[41:34];

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (st == ST_OK || st == ST_FULL || st == ST_EMPTY))
    else $error("undefined status");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && st != ST_OK |-> rid == '0 && rprio == '0)
    else $error("failed item returned an entry");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && st == ST_EMPTY |-> occ == '0)
    else $error("empty pop with nonzero occupancy");

endmodule

bind binary_max_heap_priority_queue bmhpq_checker u_bmhpq_checker (.*);
